/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int VALUE_W       = 32;
    localparam int COUNT_OUT_W   = 6;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 48;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CLEAR      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL_REJ  = 2'd1,
        ST_EMPTY_REJ = 2'd2
    } status_t;

    typedef struct packed {
        logic                   pop_ok;
        status_t                status;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   is_empty;
        logic                   is_full;
    } bdq_meta_t;

endpackage

/* rtl/bounded_deque.sv */
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit values in a ring of DEPTH slots.
//
//   group   dir  tdata fields (low bit up)
//   s_axis  in   action[2:0], push_value[34:3], zero fill to 40
//   m_axis  out  pop_value[31:0], status[33:32], entry_count[39:34],
//                is_empty[40], is_full[41], zero fill to 48
//
// One beat per cycle while no result is stalled; each result appears in the
// cycle after its beat is taken, set by the registered read of the slot memory.
// Reset clears the front pointer and count; slot contents are not cleared.
// A stalled result holds and blocks a new beat only while m_axis_tready is low.
// ----------------------------------------------------------------------------
module bounded_deque #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action[2:0], push_value[34:3]
    input  logic [bdq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pop_value[31:0], status[33:32], entry_count[39:34], is_empty[40], is_full[41]
    output logic [bdq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import bdq_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic               pend_reg, pend_next;
    logic               accept;
    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_addr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata, pop_value;
    bdq_meta_t          meta;

    assign s_axis_tready = !pend_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (action_t'(s_axis_tdata[2:0])),
        .push_value (s_axis_tdata[34:3]),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .meta       (meta)
    );

    bdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    assign pop_value     = meta.pop_ok ? ram_rdata : '0;
    assign m_axis_tvalid = pend_reg;
    assign m_axis_tdata  = {6'd0, meta.is_full, meta.is_empty, meta.entry_count,
                            meta.status, pop_value};

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("beat taken while result stalled");

    a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && meta.status != ST_DONE) |-> (pop_value == '0))
        else $error("rejected beat carries a value");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted beat gave no result");

endmodule

/* rtl/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl
// Front pointer and count of the ring; decides each operation and drives
// the slot memory access.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  bdq_pkg::action_t              action,
    input  logic [bdq_pkg::VALUE_W-1:0]   push_value,
    output logic                          ram_we,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_addr,
    output logic [bdq_pkg::VALUE_W-1:0]   ram_wdata,
    output bdq_pkg::bdq_meta_t            meta
);

    import bdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [IW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    bdq_meta_t     meta_reg, meta_next;

    logic          full, empty;
    logic [SW-1:0] back_sum, last_sum;
    logic [IW-1:0] back_pos, last_pos, front_dec, front_inc;
    logic          pop_ok;
    status_t       status;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign back_sum = SW'(front_reg) + SW'(count_reg);
    assign last_sum = back_sum - SW'(1);
    assign back_pos = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
    assign last_pos = (last_sum >= SW'(DEPTH)) ? IW'(last_sum - SW'(DEPTH)) : IW'(last_sum);
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - IW'(1);
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + IW'(1);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = front_reg;
        ram_wdata  = push_value;
        pop_ok     = 1'b0;
        status     = ST_DONE;
        if (accept)
        begin
            if ((action inside {ACT_PUSH_FRONT, ACT_PUSH_BACK}) && full)
            begin
                status = ST_FULL_REJ;
            end
            else if ((action inside {ACT_POP_FRONT, ACT_POP_BACK}) && empty)
            begin
                status = ST_EMPTY_REJ;
            end
            else
            begin
                case (action)
                    ACT_PUSH_FRONT:
                    begin
                        front_next = front_dec;
                        count_next = count_reg + CW'(1);
                        ram_we     = 1'b1;
                        ram_addr   = front_dec;
                    end
                    ACT_PUSH_BACK:
                    begin
                        count_next = count_reg + CW'(1);
                        ram_we     = 1'b1;
                        ram_addr   = back_pos;
                    end
                    ACT_POP_FRONT:
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                        ram_re     = 1'b1;
                        ram_addr   = front_reg;
                        pop_ok     = 1'b1;
                    end
                    ACT_POP_BACK:
                    begin
                        count_next = count_reg - CW'(1);
                        ram_re     = 1'b1;
                        ram_addr   = last_pos;
                        pop_ok     = 1'b1;
                    end
                    ACT_CLEAR:
                    begin
                        front_next = '0;
                        count_next = '0;
                    end
                    default:
                    begin
                        front_next = front_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        meta_next             = meta_reg;
        if (accept)
        begin
            meta_next.pop_ok      = pop_ok;
            meta_next.status      = status;
            meta_next.entry_count = COUNT_OUT_W'(count_next);
            meta_next.is_empty    = (count_next == '0);
            meta_next.is_full     = (count_next == CW'(DEPTH));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
    end

    assign meta = meta_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= IW'(DEPTH - 1))
        else $error("front pointer out of range");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("read and write in the same cycle");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status != ST_DONE) |=> ($stable(count_reg) && $stable(front_reg)))
        else $error("rejected operation changed state");

endmodule
